// ===== hw/rtl/spbd_pkg.sv =====
`timescale 1ns / 1ps
package spbd_pkg;

  localparam int NumBands  = 16;
  localparam int NumSlots  = 2 * NumBands;
  localparam int SlotW     = $clog2(NumSlots);
  localparam int BandW     = $clog2(NumBands);
  localparam int DivNumW   = 48;
  localparam int DivDenW   = 32;
  localparam int AccW      = 41;
  localparam int RatioSumW = 29;
  localparam int ProdW     = 49;
  localparam int MacW      = 50;

  // pitch-spaced band edges, last edge is the spectrum length
  localparam logic [9:0] BAND_EDGE [0:NumBands] = '{
    10'd2, 10'd3, 10'd5, 10'd7, 10'd10, 10'd14, 10'd19, 10'd27, 10'd37,
    10'd52, 10'd72, 10'd100, 10'd139, 10'd192, 10'd266, 10'd369, 10'd512
  };

  localparam logic [16:0] MIX_FAST_UP   = 17'd13107;
  localparam logic [16:0] MIX_FAST_DOWN = 17'd32768;
  localparam logic [16:0] MIX_SLOW      = 17'd59638;
  localparam logic [16:0] MIX_SLOW_INV  = 17'd5898;
  localparam logic [16:0] MIX_DECAY     = 17'd65339;
  localparam logic [16:0] MIX_DECAY_INV = 17'd197;
  localparam logic [16:0] Q16_ONE17     = 17'd65536;
  localparam logic [16:0] K_103         = 17'd67502;
  localparam logic [16:0] K_085         = 17'd55706;
  localparam logic [16:0] K_070         = 17'd45875;
  localparam logic [23:0] Q16_ONE       = 24'd65536;
  localparam logic [23:0] LIMIT_FALL    = 24'd72090;
  localparam logic [23:0] VOL_FLOOR     = 24'd13107;
  localparam logic [23:0] MAX24         = 24'hFFFFFF;
  localparam logic [MacW-1:0] ROUND_HALF = MacW'(32768);

  typedef struct packed {
    logic        channel;
    logic [8:0]  bin_index;
    logic [31:0] magnitude;
    logic        end_of_frame;
  } spbd_in_t;

  typedef struct packed {
    logic        beat;
    logic [15:0] beat_count;
    logic [23:0] volume;
    logic [23:0] threshold;
  } spbd_out_t;

  typedef struct packed {
    logic             hit;
    logic             last;
    logic [BandW-1:0] band;
    logic [7:0]       width;
  } band_hit_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ACCUM, S_MEAN_START, S_MEAN_WAIT, S_FAST_A, S_FAST_B,
    S_SLOW_A, S_SLOW_B, S_RATIO_START, S_RATIO_WAIT, S_DECAY_A, S_DECAY_B,
    S_RULE, S_SCALE_HIT, S_SCALE_T, S_SCALE_L, S_OUT
  } spbd_state_e;

  function automatic band_hit_t band_lookup(logic [8:0] idx);
    band_hit_t r;
    r = '0;
    for (int b = 0; b < NumBands; b++) begin
      if ({1'b0, idx} >= BAND_EDGE[b] && {1'b0, idx} < BAND_EDGE[b+1]) begin
        r.hit   = 1'b1;
        r.band  = BandW'(b);
        r.width = 8'(BAND_EDGE[b+1] - BAND_EDGE[b]);
        r.last  = ({1'b0, idx} == BAND_EDGE[b+1] - 10'd1);
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/spectral_band_beat_detector_unit.sv =====
`timescale 1ns / 1ps
// Bin outside a band or not closing one: accumulated if in a band, then back to idle.
// Closing bin: band mean from the 48-step shared divider, then four passes through the
// single shared multiplier for the fast and slow averages. One transaction at a time.
// End-of-frame bin: a divider run per band ratio with a nonzero slow average, then decay,
// beat rule, any scaling and output. The result register lets the next bin in.
// Reset clears all averages, counters and the beat flag and sets the fallen flag; threshold and limit go to 1.0.
module spectral_band_beat_detector_unit
  import spbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  spbd_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output spbd_out_t out_data_o
);

  spbd_state_e state_q, state_d;
  spbd_in_t    item_q, item_d;
  band_hit_t   hit_q, hit_d, bh;
  logic [AccW-1:0]      acc_q, acc_d;
  logic [31:0]          fast_q [NumSlots], fast_d [NumSlots];
  logic [31:0]          slow_q [NumSlots], slow_d [NumSlots];
  logic [31:0]          mean_q, mean_d;
  logic [16:0]          mix_q, mix_d;
  logic [MacW-1:0]      mac_q, mac_d, mac_sum, rnd;
  logic [SlotW-1:0]     idx_q, idx_d, slot;
  logic [RatioSumW-1:0] rsum_q, rsum_d;
  logic [23:0]          vol_q, vol_d, thr_q, thr_d, lim_q, lim_d, last_q, last_d, sc;
  logic                 fallen_q, fallen_d, beat_q, beat_d;
  logic [15:0]          beats_q, beats_d;
  logic                 out_valid_q, out_valid_d;
  spbd_out_t            out_q, out_d;
  logic [31:0]          mul_a;
  logic [16:0]          mul_b;
  logic [ProdW-1:0]     prod;
  logic                 div_start, div_done;
  logic [DivNumW-1:0]   div_num, div_quo;
  logic [DivDenW-1:0]   div_den;
  logic                 fall_c, rise_c, out_free;

  spbd_div #(.DIVIDEND_W(DivNumW), .DIVISOR_W(DivDenW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_num), .divisor_i(div_den),
    .done_o(div_done), .quotient_o(div_quo)
  );

  assign slot     = {item_q.channel, hit_q.band};
  assign bh       = band_lookup(item_q.bin_index);
  assign prod     = mul_a * mul_b;
  assign mac_sum  = mac_q + MacW'(prod);
  assign rnd      = MacW'(prod) + ROUND_HALF;
  assign sc       = (|rnd[MacW-1:40]) ? MAX24 : rnd[39:16];
  assign fall_c   = !fallen_q && (vol_q < thr_q);
  assign rise_c   = fallen_q && (vol_q > thr_q) && (vol_q > VOL_FLOOR);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:       if (in_valid_i) state_d = S_ACCUM;
      S_ACCUM: begin
        if (bh.hit && bh.last)          state_d = S_MEAN_START;
        else if (item_q.end_of_frame)   state_d = S_RATIO_START;
        else                            state_d = S_IDLE;
      end
      S_MEAN_START: state_d = S_MEAN_WAIT;
      S_MEAN_WAIT:  if (div_done) state_d = S_FAST_A;
      S_FAST_A:     state_d = S_FAST_B;
      S_FAST_B:     state_d = S_SLOW_A;
      S_SLOW_A:     state_d = S_SLOW_B;
      S_SLOW_B:     state_d = item_q.end_of_frame ? S_RATIO_START : S_IDLE;
      S_RATIO_START: begin
        if (slow_q[idx_q] != '0)        state_d = S_RATIO_WAIT;
        else if (&idx_q)                state_d = S_DECAY_A;
      end
      S_RATIO_WAIT: if (div_done) state_d = (&idx_q) ? S_DECAY_A : S_RATIO_START;
      S_DECAY_A:    state_d = S_DECAY_B;
      S_DECAY_B:    state_d = S_RULE;
      S_RULE: begin
        if (fall_c)      state_d = S_SCALE_HIT;
        else if (rise_c) state_d = S_SCALE_T;
        else             state_d = S_OUT;
      end
      S_SCALE_HIT:  state_d = S_OUT;
      S_SCALE_T:    state_d = S_SCALE_L;
      S_SCALE_L:    state_d = S_OUT;
      S_OUT:        if (out_free) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  always_comb begin
    item_d      = item_q;
    hit_d       = hit_q;
    acc_d       = acc_q;
    fast_d      = fast_q;
    slow_d      = slow_q;
    mean_d      = mean_q;
    mix_d       = mix_q;
    mac_d       = mac_q;
    idx_d       = idx_q;
    rsum_d      = rsum_q;
    vol_d       = vol_q;
    thr_d       = thr_q;
    lim_d       = lim_q;
    last_d      = last_q;
    fallen_d    = fallen_q;
    beat_d      = beat_q;
    beats_d     = beats_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    in_stall_o  = state_q != S_IDLE;
    case (state_q)
      S_IDLE: if (in_valid_i) item_d = in_data_i;
      S_ACCUM: begin
        hit_d = bh;
        if (bh.hit) acc_d = acc_q + AccW'(item_q.magnitude);
        idx_d  = '0;
        rsum_d = '0;
      end
      S_MEAN_START: begin
        div_start = 1'b1;
        div_num   = DivNumW'(acc_q);
        div_den   = DivDenW'(hit_q.width);
        acc_d     = '0;
      end
      S_MEAN_WAIT: if (div_done) mean_d = (|div_quo[DivNumW-1:32]) ? '1 : div_quo[31:0];
      S_FAST_A: begin
        mix_d = (mean_q > fast_q[slot]) ? MIX_FAST_UP : MIX_FAST_DOWN;
        mul_a = fast_q[slot];
        mul_b = mix_d;
        mac_d = MacW'(prod) + ROUND_HALF;
      end
      S_FAST_B: begin
        mul_a = mean_q;
        mul_b = Q16_ONE17 - mix_q;
        fast_d[slot] = mac_sum[47:16];
      end
      S_SLOW_A: begin
        mul_a = slow_q[slot];
        mul_b = MIX_SLOW;
        mac_d = MacW'(prod) + ROUND_HALF;
      end
      S_SLOW_B: begin
        mul_a = mean_q;
        mul_b = MIX_SLOW_INV;
        slow_d[slot] = mac_sum[47:16];
        idx_d  = '0;
        rsum_d = '0;
      end
      S_RATIO_START: begin
        if (slow_q[idx_q] != '0) begin
          div_start = 1'b1;
          div_num   = {fast_q[idx_q], 16'd0};
          div_den   = slow_q[idx_q];
        end else if (!(&idx_q)) begin
          idx_d = idx_q + SlotW'(1);
        end
      end
      S_RATIO_WAIT: begin
        if (div_done) begin
          rsum_d = rsum_q + RatioSumW'((|div_quo[DivNumW-1:24]) ? MAX24 : div_quo[23:0]);
          idx_d  = idx_q + SlotW'(1);
        end
      end
      S_DECAY_A: begin
        vol_d = rsum_q[RatioSumW-1] ? MAX24 : rsum_q[RatioSumW-2:4];
        mul_a = 32'(thr_q);
        mul_b = MIX_DECAY;
        mac_d = MacW'(prod) + ROUND_HALF;
      end
      S_DECAY_B: begin
        mul_a = 32'(lim_q);
        mul_b = MIX_DECAY_INV;
        thr_d = mac_sum[39:16];
      end
      S_RULE: beat_d = 1'b0;
      S_SCALE_HIT: begin
        mul_a    = 32'(last_q);
        mul_b    = K_103;
        thr_d    = sc;
        lim_d    = LIMIT_FALL;
        fallen_d = 1'b1;
      end
      S_SCALE_T: begin
        mul_a    = 32'(vol_q);
        mul_b    = K_085;
        thr_d    = (sc < Q16_ONE) ? Q16_ONE : sc;
        beats_d  = beats_q + 16'd1;
        last_d   = vol_q;
        fallen_d = 1'b0;
        beat_d   = 1'b1;
      end
      S_SCALE_L: begin
        mul_a = 32'(vol_q);
        mul_b = K_070;
        lim_d = (sc < Q16_ONE) ? Q16_ONE : sc;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{beat: beat_q, beat_count: beats_q, volume: vol_q, threshold: thr_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      for (int i = 0; i < NumSlots; i++) begin
        fast_q[i] <= '0;
        slow_q[i] <= '0;
      end
      idx_q       <= '0;
      rsum_q      <= '0;
      thr_q       <= Q16_ONE;
      lim_q       <= Q16_ONE;
      last_q      <= '0;
      fallen_q    <= 1'b1;
      beat_q      <= 1'b0;
      beats_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      fast_q      <= fast_d;
      slow_q      <= slow_d;
      idx_q       <= idx_d;
      rsum_q      <= rsum_d;
      thr_q       <= thr_d;
      lim_q       <= lim_d;
      last_q      <= last_d;
      fallen_q    <= fallen_d;
      beat_q      <= beat_d;
      beats_q     <= beats_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    hit_q  <= hit_d;
    mean_q <= mean_d;
    mix_q  <= mix_d;
    mac_q  <= mac_d;
    vol_q  <= vol_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

// ===== hw/rtl/spbd_div.sv =====
`timescale 1ns / 1ps
module spbd_div #(
  parameter int DIVIDEND_W = 48,
  parameter int DIVISOR_W  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);
  localparam int CntW = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W:0]    rem_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  den_q;
  logic [CntW-1:0]       cnt_q;
  logic                  busy_q, done_q;
  logic [DIVISOR_W:0]    shifted;
  logic                  fits;

  assign shifted = {rem_q[DIVISOR_W-1:0], quo_q[DIVIDEND_W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dividend_i;
      den_q  <= divisor_i;
      cnt_q  <= CntW'(DIVIDEND_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q  <= fits ? shifted - {1'b0, den_q} : shifted;
      quo_q  <= {quo_q[DIVIDEND_W-2:0], fits};
      cnt_q  <= cnt_q - CntW'(1);
      busy_q <= cnt_q != CntW'(1);
      done_q <= cnt_q == CntW'(1);
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

// ===== verif/spectral_band_beat_detector_unit_tb.sv =====
`timescale 1ns / 1ps
module spectral_band_beat_detector_unit_tb;
  import spbd_pkg::*;

  localparam int  TARGET_BINS = 1200;
  localparam longint CYCLE_LIMIT = 20_000_000;

  typedef struct {
    spbd_in_t bin;
    bit       drain;
  } pending_bin_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  spbd_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  spbd_out_t out_data_o;

  spectral_band_beat_detector_unit DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always #4 clk_i = ~clk_i;

  pending_bin_t pending_bins[$];
  spbd_out_t    expected_frames[$];

  // detector image
  logic [40:0] acc_m;
  logic [31:0] fast_m [NumSlots];
  logic [31:0] slow_m [NumSlots];
  logic [23:0] thr_m, lim_m, hit_vol_m;
  logic        fallen_m;
  logic [15:0] beats_m;

  int     errors = 0;
  int     bins_sent = 0;
  int     frames_checked = 0;
  int     beats_checked = 0;
  int     phase = 0;
  longint cycles = 0;
  bit     in_taken = 1'b0;
  bit     hold_armed = 1'b1;
  int     hold_left = 0;

  function automatic logic [31:0] mix_q16(logic [31:0] a, logic [31:0] b, logic [16:0] c);
    logic [63:0] s;
    s = 64'(a) * 64'(c) + 64'(b) * (64'd65536 - 64'(c)) + 64'd32768;
    return s[47:16];
  endfunction

  function automatic logic [23:0] scale_sat(logic [23:0] v, logic [16:0] k);
    logic [63:0] p;
    p = (64'(v) * 64'(k) + 64'd32768) >> 16;
    return (p > 64'(MAX24)) ? MAX24 : p[23:0];
  endfunction

  task automatic track_bin(spbd_in_t it);
    int          slot;
    logic [63:0] mean64, r;
    logic [31:0] mean, ratio_acc;
    logic [23:0] vol, t, l;
    spbd_out_t   res;
    logic        beat;
    for (int b = 0; b < NumBands; b++) begin
      if ({1'b0, it.bin_index} >= BAND_EDGE[b] && {1'b0, it.bin_index} < BAND_EDGE[b+1]) begin
        acc_m = acc_m + 41'(it.magnitude);
        if ({1'b0, it.bin_index} == BAND_EDGE[b+1] - 10'd1) begin
          slot = it.channel * NumBands + b;
          mean64 = 64'(acc_m) / 64'(BAND_EDGE[b+1] - BAND_EDGE[b]);
          mean = (mean64 > 64'hFFFFFFFF) ? 32'hFFFFFFFF : mean64[31:0];
          fast_m[slot] = mix_q16(fast_m[slot], mean,
                                 (mean > fast_m[slot]) ? MIX_FAST_UP : MIX_FAST_DOWN);
          slow_m[slot] = mix_q16(slow_m[slot], mean, MIX_SLOW);
          acc_m = '0;
        end
        break;
      end
    end
    if (!it.end_of_frame) return;
    ratio_acc = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (slow_m[i] != 0) begin
        r = (64'(fast_m[i]) << 16) / 64'(slow_m[i]);
        ratio_acc += (r > 64'(MAX24)) ? 32'(MAX24) : r[31:0];
      end
    end
    vol = ((ratio_acc / NumBands) > 32'(MAX24)) ? MAX24 : 24'(ratio_acc / NumBands);
    thr_m = 24'(mix_q16(32'(thr_m), 32'(lim_m), MIX_DECAY));
    beat = 1'b0;
    if (!fallen_m) begin
      if (vol < thr_m) begin
        fallen_m = 1'b1;
        thr_m = scale_sat(hit_vol_m, K_103);
        lim_m = LIMIT_FALL;
      end
    end else if (vol > thr_m && vol > VOL_FLOOR) begin
      t = scale_sat(vol, K_085);
      l = scale_sat(vol, K_070);
      beats_m++;
      hit_vol_m = vol;
      fallen_m = 1'b0;
      thr_m = (t < Q16_ONE) ? Q16_ONE : t;
      lim_m = (l < Q16_ONE) ? Q16_ONE : l;
      beat = 1'b1;
    end
    res.beat = beat;
    res.beat_count = beats_m;
    res.volume = vol;
    res.threshold = thr_m;
    expected_frames.push_back(res);
  endtask

  task automatic queue_bin(logic ch, int idx, logic [31:0] mag, logic eof, bit drain = 1'b0);
    pending_bin_t p;
    p.bin.channel = ch;
    p.bin.bin_index = 9'(idx);
    p.bin.magnitude = mag;
    p.bin.end_of_frame = eof;
    p.drain = drain;
    pending_bins.push_back(p);
  endtask

  // monitor and predictor
  always @(posedge clk_i) begin
    spbd_out_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("spectral_band_beat_detector_unit: mismatch");
      $finish;
    end
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) track_bin(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected result transaction: %p", out_data_o);
        errors++;
      end else begin
        e = expected_frames.pop_front();
        frames_checked++;
        beats_checked += e.beat;
        if (out_data_o.beat !== e.beat) begin
          $error("beat: expected %0d, got %0d", e.beat, out_data_o.beat); errors++;
        end
        if (out_data_o.beat_count !== e.beat_count) begin
          $error("beat_count: expected %0d, got %0d", e.beat_count, out_data_o.beat_count);
          errors++;
        end
        if (out_data_o.volume !== e.volume) begin
          $error("volume: expected %0d, got %0d", e.volume, out_data_o.volume); errors++;
        end
        if (out_data_o.threshold !== e.threshold) begin
          $error("threshold: expected %0d, got %0d", e.threshold, out_data_o.threshold);
          errors++;
        end
      end
    end
  end

  // sender
  always @(negedge clk_i) begin
    int idle_pct;
    pending_bin_t nxt;
    idle_pct = (phase == 0) ? 14 : (phase == 1) ? 63 : 0;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_bins.size() == 0 || $urandom_range(99) < idle_pct ||
          (pending_bins[0].drain && expected_frames.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else begin
        nxt = pending_bins.pop_front();
        in_valid_i <= 1'b1;
        in_data_i <= nxt.bin;
        bins_sent++;
        phase = (bins_sent < TARGET_BINS / 3) ? 0 : (bins_sent < 2 * TARGET_BINS / 3) ? 1 : 2;
      end
    end
  end

  // long receiver hold-off once a frame result is due late in the run
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (hold_armed && phase == 2 && expected_frames.size() != 0) begin
      hold_armed = 1'b0;
      hold_left = 6000;
    end
  end

  // receiver
  always @(negedge clk_i) begin
    int idle_pct;
    idle_pct = (phase == 0) ? 63 : (phase == 1) ? 14 : 0;
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < idle_pct);
  end

  initial begin
    int frames, sh, bw, first, last;
    logic [31:0] m;
    acc_m = '0;
    for (int i = 0; i < NumSlots; i++) begin
      fast_m[i] = '0;
      slow_m[i] = '0;
    end
    thr_m = Q16_ONE; lim_m = Q16_ONE; hit_vol_m = '0; fallen_m = 1'b1; beats_m = '0;

    // directed: empty volume, out-of-band bins, extremes, out-of-order bins
    queue_bin(1'b0, 0, 32'h0, 1'b1);
    queue_bin(1'b0, 1, 32'hFFFFFFFF, 1'b0);
    queue_bin(1'b0, 2, 32'hFFFFFFFF, 1'b0);
    queue_bin(1'b1, 2, 32'h0, 1'b1);
    for (int i = 369; i < 512; i += 13) queue_bin(1'b1, i, 32'hFFFFFFFF, 1'b0);
    queue_bin(1'b1, 511, 32'hFFFFFFFF, 1'b0);
    queue_bin(1'b0, 300, 32'h12345678, 1'b0);
    queue_bin(1'b0, 6, 32'h00000100, 1'b0);
    queue_bin(1'b1, 14, 32'hA5A5A5A5, 1'b0);
    queue_bin(1'b1, 18, 32'h5A5A5A5A, 1'b1);
    queue_bin(1'b0, 3, 32'h00000001, 1'b0, 1'b1);
    queue_bin(1'b0, 4, 32'h7FFFFFFF, 1'b1);
    queue_bin(1'b1, 511, 32'h00000000, 1'b1);

    frames = 0;
    while (pending_bins.size() < TARGET_BINS) begin
      if ($urandom_range(99) < 80) begin
        sh = $urandom_range(4, 20) + (($urandom_range(99) < 20) ? 3 : 0);
        for (int ch = 0; ch < 2; ch++) begin
          for (int b = 0; b < NumBands; b++) begin
            bw = int'(BAND_EDGE[b+1]) - int'(BAND_EDGE[b]);
            last = int'(BAND_EDGE[b+1]) - 1;
            first = (bw <= 8 && $urandom_range(7) == 0) ? int'(BAND_EDGE[b]) : last;
            for (int i = first; i <= last; i++) begin
              m = 32'($urandom_range(64, 255)) << sh;
              queue_bin(ch[0], i, m, (ch == 1 && i == 511),
                        (i == first && ch == 0 && b == 0 && frames % 10 == 9));
            end
          end
        end
        frames++;
      end else begin
        repeat ($urandom_range(4, 10))
          queue_bin(1'($urandom_range(1)), int'($urandom_range(511)), $urandom,
                    ($urandom_range(7) == 0));
      end
    end

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    do @(posedge clk_i);
    while (pending_bins.size() != 0 || in_valid_i || expected_frames.size() != 0);
    repeat (3000) @(posedge clk_i);
    if (expected_frames.size() != 0) begin
      $error("%0d result transactions never arrived", expected_frames.size());
      errors++;
    end
    $display("covered %0d bins, %0d spectrum frames, %0d results checked, %0d with a beat",
             bins_sent, frames, frames_checked, beats_checked);
    if (errors == 0) begin
      $display("spectral_band_beat_detector_unit: match");
    end else begin
      $display("spectral_band_beat_detector_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/spbd_pkg.sv
hw/rtl/spbd_div.sv
hw/rtl/spectral_band_beat_detector_unit.sv
verif/spectral_band_beat_detector_unit_tb.sv
